FILE: rtl/wur_pkg.sv
`default_nettype none

package wur_pkg;

  // magnitude width used by the divider; the ports always carry 96 bits
  localparam int MAG_WIDTH = 96;
  localparam int LOW_WIDTH = 64;
  localparam int HIGH_WIDTH = 32;
  localparam int PORT_WIDTH = LOW_WIDTH + HIGH_WIDTH;
  localparam int CNT_WIDTH = (MAG_WIDTH > 1) ? $clog2(MAG_WIDTH) : 1;

  typedef logic [MAG_WIDTH-1:0] mag_t;
  typedef logic [CNT_WIDTH-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/wide_unsigned_remainder_top.sv
`default_nettype none

// channel   | ports                                   | handshake
// ----------+-----------------------------------------+------------------------------
// input     | in_dividend_*, in_divisor_*             | transfer when start & !busy
// result    | out_remainder_*, out_divide_by_zero     | one-cycle strobe on out_valid
//
// one shared compare-subtract unit handles one remainder bit per cycle: a transfer with
// a nonzero divisor keeps busy high until every bit is done, and the result strobes in
// the cycle after, when busy is low again, so a new transfer can be taken in that same cycle.
// a zero divisor gives its result in the cycle after the transfer, busy stays low.
// rst_n is synchronous; it clears the sequencer and the strobe only.
// the receiver cannot stall: each result is shown for exactly one cycle.

module wide_unsigned_remainder_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [wur_pkg::LOW_WIDTH-1:0]  in_dividend_low,
  input  wire logic [wur_pkg::HIGH_WIDTH-1:0] in_dividend_high,
  input  wire logic                          in_dividend_negative,
  input  wire logic [wur_pkg::LOW_WIDTH-1:0]  in_divisor_low,
  input  wire logic [wur_pkg::HIGH_WIDTH-1:0] in_divisor_high,
  output logic                               out_valid,
  output logic [wur_pkg::LOW_WIDTH-1:0]       out_remainder_low,
  output logic [wur_pkg::HIGH_WIDTH-1:0]      out_remainder_high,
  output logic                               out_remainder_negative,
  output logic                               out_divide_by_zero
);

  wur_pkg::state_t state_r, state_nxt;
  wur_pkg::cnt_t   cnt_r, cnt_nxt;
  wur_pkg::mag_t   num_r, num_nxt;
  wur_pkg::mag_t   den_r, den_nxt;
  wur_pkg::mag_t   rem_r, rem_nxt;
  logic            neg_r, neg_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [wur_pkg::PORT_WIDTH-1:0]    out_rem_r, out_rem_nxt;
  logic                              out_neg_r, out_neg_nxt;
  logic                              out_dbz_r, out_dbz_nxt;

  wur_pkg::mag_t                     in_num;
  wur_pkg::mag_t                     in_den;
  logic                              accept;
  logic [wur_pkg::MAG_WIDTH:0]       shifted;
  logic [wur_pkg::MAG_WIDTH:0]       diff;
  wur_pkg::mag_t                     step_rem;

  // size casts drop or zero-fill bits beyond the magnitude width
  assign in_num = wur_pkg::MAG_WIDTH'({in_dividend_high, in_dividend_low});
  assign in_den = wur_pkg::MAG_WIDTH'({in_divisor_high, in_divisor_low});
  assign accept = start && (state_r == wur_pkg::ST_IDLE);

  // shared unit: shift in the next dividend bit, trial subtract, keep if no borrow
  assign shifted  = {rem_r, num_r[wur_pkg::MAG_WIDTH-1]};
  assign diff     = shifted - {1'b0, den_r};
  assign step_rem = diff[wur_pkg::MAG_WIDTH] ? shifted[wur_pkg::MAG_WIDTH-1:0]
                                             : diff[wur_pkg::MAG_WIDTH-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_rem_nxt   = out_rem_r;
    out_neg_nxt   = out_neg_r;
    out_dbz_nxt   = out_dbz_r;
    case (state_r)
      wur_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_den == '0) begin
            out_valid_nxt = 1'b1;
            out_rem_nxt   = '0;
            out_neg_nxt   = 1'b0;
            out_dbz_nxt   = 1'b1;
          end else begin
            state_nxt = wur_pkg::ST_RUN;
            cnt_nxt   = wur_pkg::CNT_WIDTH'(wur_pkg::MAG_WIDTH - 1);
            num_nxt   = in_num;
            den_nxt   = in_den;
            rem_nxt   = '0;
            neg_nxt   = in_dividend_negative;
          end
        end
      end
      wur_pkg::ST_RUN: begin
        rem_nxt = step_rem;
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt     = wur_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          out_rem_nxt   = wur_pkg::PORT_WIDTH'(step_rem);
          out_neg_nxt   = neg_r;
          out_dbz_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = wur_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wur_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    neg_r     <= neg_nxt;
    out_rem_r <= out_rem_nxt;
    out_neg_r <= out_neg_nxt;
    out_dbz_r <= out_dbz_nxt;
  end

  assign busy                   = (state_r != wur_pkg::ST_IDLE);
  assign out_valid              = out_valid_r;
  assign out_remainder_low      = out_rem_r[wur_pkg::LOW_WIDTH-1:0];
  assign out_remainder_high     = out_rem_r[wur_pkg::PORT_WIDTH-1:wur_pkg::LOW_WIDTH];
  assign out_remainder_negative = out_neg_r;
  assign out_divide_by_zero     = out_dbz_r;

  // a zero divisor answers in the next cycle without going busy
  a_zero_div_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_den == '0) |=> (out_valid && out_divide_by_zero && !busy))
    else $error("zero divisor result missing");

  // a nonzero divisor starts the iteration
  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_den != '0) |=>
      (busy && cnt_r == wur_pkg::CNT_WIDTH'(wur_pkg::MAG_WIDTH - 1)))
    else $error("iteration did not start");

  // last step hands over the result
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && cnt_r == '0) |=> (out_valid && !busy && !out_divide_by_zero))
    else $error("result not strobed after last step");

  // a divide-by-zero result carries a clean zero
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |->
      (out_remainder_low == '0 && out_remainder_high == '0 && !out_remainder_negative))
    else $error("divide-by-zero result not zero");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;

  typedef logic [wur_pkg::PORT_WIDTH-1:0] word96_t;

  typedef struct {
    logic [wur_pkg::LOW_WIDTH-1:0]  dvd_lo;
    logic [wur_pkg::HIGH_WIDTH-1:0] dvd_hi;
    logic                           dvd_neg;
    logic [wur_pkg::LOW_WIDTH-1:0]  dvs_lo;
    logic [wur_pkg::HIGH_WIDTH-1:0] dvs_hi;
    int unsigned                    idle_pct;
  } div_req_t;

  typedef struct {
    logic [wur_pkg::LOW_WIDTH-1:0]  rem_lo;
    logic [wur_pkg::HIGH_WIDTH-1:0] rem_hi;
    logic                           rem_neg;
    logic                           dbz;
  } div_res_t;

  localparam int unsigned RANDOM_ITEMS = 532;
  localparam int unsigned MAX_HOLD_OFF = 130;
  localparam int unsigned MAX_REPORTS  = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic out_valid;
  logic [wur_pkg::LOW_WIDTH-1:0]  out_remainder_low;
  logic [wur_pkg::HIGH_WIDTH-1:0] out_remainder_high;
  logic out_remainder_negative;
  logic out_divide_by_zero;

  div_req_t cur_req = '{default: '0};
  div_req_t div_pending[$];
  div_res_t rem_expected[$];
  int unsigned hold_off = 0;
  int unsigned divisions_queued = 0;
  int unsigned results_seen = 0;
  int unsigned fail_cnt = 0;

  wide_unsigned_remainder_top u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_dividend_low        (cur_req.dvd_lo),
    .in_dividend_high       (cur_req.dvd_hi),
    .in_dividend_negative   (cur_req.dvd_neg),
    .in_divisor_low         (cur_req.dvs_lo),
    .in_divisor_high        (cur_req.dvs_hi),
    .out_valid              (out_valid),
    .out_remainder_low      (out_remainder_low),
    .out_remainder_high     (out_remainder_high),
    .out_remainder_negative (out_remainder_negative),
    .out_divide_by_zero     (out_divide_by_zero)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // magnitudes are cut to the divider width; the sign only survives a nonzero divisor
  function automatic div_res_t predict_remainder(div_req_t r);
    wur_pkg::mag_t num;
    wur_pkg::mag_t den;
    word96_t rem_w;
    div_res_t res;
    num = wur_pkg::mag_t'({r.dvd_hi, r.dvd_lo});
    den = wur_pkg::mag_t'({r.dvs_hi, r.dvs_lo});
    res = '{default: '0};
    if (den == '0) begin
      res.dbz = 1'b1;
    end else begin
      rem_w = wur_pkg::PORT_WIDTH'(num % den);
      res.rem_lo = rem_w[wur_pkg::LOW_WIDTH-1:0];
      res.rem_hi = rem_w[wur_pkg::PORT_WIDTH-1:wur_pkg::LOW_WIDTH];
      res.rem_neg = r.dvd_neg;
    end
    return res;
  endfunction

  function automatic word96_t random_word96();
    return {$urandom, $urandom, $urandom};
  endfunction

  task automatic queue_division(input word96_t num, input logic neg, input word96_t den,
                                input int unsigned idle);
    div_req_t r;
    r.dvd_lo = num[wur_pkg::LOW_WIDTH-1:0];
    r.dvd_hi = num[wur_pkg::PORT_WIDTH-1:wur_pkg::LOW_WIDTH];
    r.dvd_neg = neg;
    r.dvs_lo = den[wur_pkg::LOW_WIDTH-1:0];
    r.dvs_hi = den[wur_pkg::PORT_WIDTH-1:wur_pkg::LOW_WIDTH];
    r.idle_pct = idle;
    div_pending.push_back(r);
    divisions_queued++;
  endtask

  task automatic check_field(input string label, input word96_t want, input word96_t got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t %s: expected %h, got %h", $time, label, want, got);
    end
  endtask

  // driver: one item held on the ports until busy is low at an edge
  always @(posedge clk) begin : drive
    div_req_t next_req;
    if (!rst_n) begin
      start <= 1'b0;
      hold_off <= 0;
    end else begin
      if (start && !busy)
        rem_expected.push_back(predict_remainder(cur_req));
      if (!start || !busy) begin
        if (hold_off != 0) begin
          hold_off <= hold_off - 1;
          start <= 1'b0;
        end else if (div_pending.size() != 0) begin
          if ($urandom_range(99) < div_pending[0].idle_pct) begin
            // long gaps so that the next start lands anywhere in the busy window
            hold_off <= $urandom_range(MAX_HOLD_OFF, 1);
            start <= 1'b0;
          end else begin
            next_req = div_pending.pop_front();
            cur_req <= next_req;
            start <= 1'b1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    div_res_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (rem_expected.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t unexpected result: expected none, got %h_%h neg %b dbz %b", $time,
                   out_remainder_high, out_remainder_low, out_remainder_negative,
                   out_divide_by_zero);
      end else begin
        want = rem_expected.pop_front();
        check_field("remainder_low", word96_t'(want.rem_lo), word96_t'(out_remainder_low));
        check_field("remainder_high", word96_t'(want.rem_hi), word96_t'(out_remainder_high));
        check_field("remainder_negative", word96_t'(want.rem_neg),
                    word96_t'(out_remainder_negative));
        check_field("divide_by_zero", word96_t'(want.dbz), word96_t'(out_divide_by_zero));
      end
    end
  end

  initial begin
    word96_t all_ones;
    word96_t num;
    word96_t den;
    int unsigned idle_by_phase [4];
    int unsigned idle;
    all_ones = '1;
    idle_by_phase = '{0, 58, 0, 32};

    // zero and unit divisors, with and without the dividend sign
    queue_division('0, 1'b0, '0, 0);
    queue_division(all_ones, 1'b1, '0, 0);
    queue_division('0, 1'b0, word96_t'(1), 0);
    queue_division(all_ones, 1'b0, word96_t'(1), 0);
    // negative zero remainders, then boundary and mixed-sign cases
    queue_division(all_ones, 1'b1, all_ones, 0);
    queue_division(word96_t'(12345), 1'b1, word96_t'(12345), 0);
    queue_division('0, 1'b1, all_ones, 0);
    queue_division(all_ones, 1'b0, all_ones - 1, 0);
    queue_division(word96_t'(100), 1'b1, word96_t'(7), 0);
    queue_division(word96_t'(7), 1'b0, word96_t'(100), 0);
    queue_division(word96_t'(1) << 95, 1'b0, (word96_t'(1) << 95) - 1, 0);
    queue_division((word96_t'(1) << 95) - 1, 1'b1, word96_t'(1) << 95, 0);
    queue_division(all_ones, 1'b0, word96_t'(1) << 64, 0);
    queue_division(word96_t'(1) << 64, 1'b1, (word96_t'(1) << 64) - 1, 0);
    queue_division(all_ones, 1'b1, word96_t'(3), 0);
    queue_division({32'hFFFF_FFFF, 64'h0}, 1'b0, {32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 0);
    queue_division(all_ones, 1'b0, word96_t'(2), 0);
    queue_division({24{4'hA}}, 1'b1, {24{4'h5}}, 0);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      idle = idle_by_phase[(i * 4) / RANDOM_ITEMS];
      num = random_word96();
      if ($urandom_range(9) < 3)
        num = num >> $urandom_range(95);
      case ($urandom_range(9))
        0:       den = '0;
        1, 2:    den = random_word96();
        3, 4, 5: den = random_word96() >> $urandom_range(95);
        6, 7:    den = random_word96() >> $urandom_range(95, 70);
        8:       den = num >> $urandom_range(3, 1);
        default: den = num;
      endcase
      queue_division(num, 1'($urandom_range(1)), den, idle);
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (results_seen < divisions_queued) @(posedge clk);
    repeat (wur_pkg::MAG_WIDTH + 8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
